// ===== hw/rtl/sshd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sshd_pkg
// Shared types and constants for the SSH binary packet deframer.
// ----------------------------------------------------------------------------
package sshd_pkg;

  // Framing phase, one-hot
  typedef enum logic [4:0] {
    PH_LEN     = 5'b00001,
    PH_PAD     = 5'b00010,
    PH_FIRST   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_DISCONNECT = 3'd1,
    ST_UNEXPECTED = 3'd2,
    ST_OVERSIZE   = 3'd3,
    ST_BADPAD     = 3'd4,
    ST_UNAUTH     = 3'd5
  } status_e;

  // Message types screened on the first payload byte
  localparam logic [7:0] MSG_DISCONNECT = 8'd1;
  localparam logic [7:0] MSG_IGNORE     = 8'd2;
  localparam logic [7:0] MSG_DEBUG      = 8'd4;

  // Register map (word index)
  localparam logic [1:0] REG_MAX_LEN  = 2'd0;
  localparam logic [1:0] REG_UNAUTH   = 2'd1;
  localparam logic [1:0] REG_AUTH     = 2'd2;
  localparam logic [1:0] REG_EXP_TYPE = 2'd3;

  localparam int unsigned ADDR_W = 4;

  // Register reset values
  localparam logic [19:0] MAX_LEN_RST  = 20'd35000;
  localparam logic [7:0]  UNAUTH_RST   = 8'd30;
  localparam logic        AUTH_RST     = 1'b0;
  localparam logic [7:0]  EXP_TYPE_RST = 8'd0;

  typedef struct packed {
    logic [19:0] max_len;
    logic [7:0]  unauth_limit;
    logic        authorized;
    logic [7:0]  expected_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last;
    status_e     status;
    logic [31:0] packet_index;
  } res_t;

endpackage : sshd_pkg
`default_nettype wire

// ===== hw/rtl/sshd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sshd_cfg
// APB register bank: packet length limit, unauthenticated limit, auth flag,
// expected message type.
// ----------------------------------------------------------------------------
module sshd_cfg (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [sshd_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sshd_pkg::cfg_t             cfg_o
);
  import sshd_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_len       <= MAX_LEN_RST;
      cfg_q.unauth_limit  <= UNAUTH_RST;
      cfg_q.authorized    <= AUTH_RST;
      cfg_q.expected_type <= EXP_TYPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_LEN:  cfg_q.max_len       <= pwdata[19:0];
        REG_UNAUTH:   cfg_q.unauth_limit  <= pwdata[7:0];
        REG_AUTH:     cfg_q.authorized    <= pwdata[0];
        REG_EXP_TYPE: cfg_q.expected_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_LEN:  prdata = {12'd0, cfg_q.max_len};
      REG_UNAUTH:   prdata = {24'd0, cfg_q.unauth_limit};
      REG_AUTH:     prdata = {31'd0, cfg_q.authorized};
      REG_EXP_TYPE: prdata = {24'd0, cfg_q.expected_type};
      default:      prdata = 32'd0;
    endcase
  end

endmodule : sshd_cfg
`default_nettype wire

// ===== hw/rtl/sshd_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sshd_frame
// Per-byte framing state machine: length, padding, type screen, payload,
// padding skip. Sticky halt on any error or disconnect.
// ----------------------------------------------------------------------------
module sshd_frame (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  wire  [7:0]           byte_i,
  input  sshd_pkg::cfg_t       cfg_i,
  output logic                 emit_o,
  output sshd_pkg::res_t       res_o
);
  import sshd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  pad_left_q, pad_left_d;
  logic [19:0] pay_left_q, pay_left_d;
  logic        discard_q, discard_d;
  logic [31:0] pkt_cnt_q, pkt_cnt_d;
  logic        halted_q, halted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN;
      len_q      <= '0;
      cnt_q      <= '0;
      pad_left_q <= '0;
      pay_left_q <= '0;
      discard_q  <= 1'b0;
      pkt_cnt_q  <= '0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      pad_left_q <= pad_left_d;
      pay_left_q <= pay_left_d;
      discard_q  <= discard_d;
      pkt_cnt_q  <= pkt_cnt_d;
      halted_q   <= halted_d;
    end
  end

  always_comb begin
    logic        do_pay;
    logic        pay_drop;
    logic        drop_type;
    logic        last;
    logic        next_pkt;
    logic        fail;
    status_e     st;
    logic [7:0]  pbyte;

    phase_d    = phase_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    pad_left_d = pad_left_q;
    pay_left_d = pay_left_q;
    discard_d  = discard_q;
    pkt_cnt_d  = pkt_cnt_q;
    halted_d   = halted_q;
    do_pay     = 1'b0;
    pay_drop   = discard_q;
    drop_type  = (byte_i == MSG_IGNORE) || (byte_i == MSG_DEBUG);
    last       = (pay_left_q == 20'd1);
    next_pkt   = 1'b0;
    fail       = 1'b0;
    st         = ST_DATA;
    pbyte      = byte_i;
    emit_o     = 1'b0;

    if (step_i && !halted_q) begin
      case (phase_q)
        PH_LEN: begin
          len_d = {len_q[23:0], byte_i};
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            pkt_cnt_d = pkt_cnt_q + 32'd1;
            if (len_d > {12'd0, cfg_i.max_len}) begin
              fail  = 1'b1;
              st    = ST_OVERSIZE;
              pbyte = 8'd0;
            end else begin
              phase_d = PH_PAD;
            end
          end
        end
        PH_PAD: begin
          if (len_q <= ({24'd0, byte_i} + 32'd1)) begin
            fail  = 1'b1;
            st    = ST_BADPAD;
            pbyte = 8'd0;
          end else begin
            // length already bounded by the 20-bit limit
            pay_left_d = len_q[19:0] - {12'd0, byte_i} - 20'd1;
            pad_left_d = byte_i;
            phase_d    = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (!cfg_i.authorized && (pkt_cnt_q > {24'd0, cfg_i.unauth_limit})) begin
            fail  = 1'b1;
            st    = ST_UNAUTH;
            pbyte = 8'd0;
          end else if (byte_i == MSG_DISCONNECT) begin
            fail = 1'b1;
            st   = ST_DISCONNECT;
          end else if (!drop_type && (cfg_i.expected_type != 8'd0) &&
                       (cfg_i.expected_type != byte_i)) begin
            fail = 1'b1;
            st   = ST_UNEXPECTED;
          end else begin
            discard_d = drop_type;
            pay_drop  = drop_type;
            do_pay    = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          do_pay = 1'b1;
        end
        PH_SKIP: begin
          pad_left_d = pad_left_q - 8'd1;
          if (pad_left_q == 8'd1) begin
            next_pkt = 1'b1;
          end
        end
        default: begin
          next_pkt = 1'b1;
        end
      endcase

      if (do_pay) begin
        emit_o     = !pay_drop;
        pay_left_d = pay_left_q - 20'd1;
        if (last) begin
          if (pad_left_q == 8'd0) begin
            next_pkt = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end

      if (fail) begin
        halted_d = 1'b1;
        emit_o   = 1'b1;
      end

      if (next_pkt) begin
        phase_d    = PH_LEN;
        len_d      = '0;
        cnt_d      = '0;
        discard_d  = 1'b0;
        pay_left_d = '0;
        pad_left_d = '0;
      end
    end

    res_o.payload_byte = pbyte;
    res_o.last         = do_pay && last && !fail;
    res_o.status       = st;
    res_o.packet_index = pkt_cnt_d;
  end

endmodule : sshd_frame
`default_nettype wire

// ===== hw/rtl/ssh_packet_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_packet_deframer_top
// Deframes unencrypted SSH binary packets from a received byte stream and
// delivers the payload bytes with a last marker and a status code.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | rx_byte_i
//  out     | source    | out_valid_o / out_stall_i| payload_byte_o, last_of_payload_o,
//          |           |                          | status_o, packet_index_o
//  cfg     | APB slave | psel/penable/pready      | paddr, pwdata, prdata
//
//  One byte per cycle sustained while out_stall_i is low. An accepted byte sits
//  in the input register and is framed on its way into the result register,
//  which drives the output.
//  Reset clears framing state, packet count, halt flag and both valid bits;
//  registers return to their documented defaults.
//  Bytes of the length, padding-length and padding fields, and of dropped
//  (ignore/debug) payloads, give no transaction on the output unless they raise an error.
//  in_stall_o rises only while a result is held and out_stall_i is high.
//  After an error or a disconnect the block keeps taking bytes but drops
//  them until reset.
//
// ----------------------------------------------------------------------------
module ssh_packet_deframer_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // input byte stream
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [7:0]                 rx_byte_i,
  // result stream
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [7:0]                 payload_byte_o,
  output logic                       last_of_payload_o,
  output logic [2:0]                 status_o,
  output logic [31:0]                packet_index_o,
  // configuration
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [sshd_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sshd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       emit;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;

  // result register
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;

  logic       out_free;   // result register free, or emptied this cycle
  logic       step;       // input register hands its byte to the framer
  logic       in_take;    // input transaction completes

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step && emit) begin
      out_res_q <= res;
    end
  end

  sshd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sshd_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  assign out_valid_o       = out_valid_q;
  assign payload_byte_o    = out_res_q.payload_byte;
  assign last_of_payload_o = out_res_q.last;
  assign status_o          = out_res_q.status;
  assign packet_index_o    = out_res_q.packet_index;

endmodule : ssh_packet_deframer_top
`default_nettype wire

// ===== hw/rtl/sshd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sshd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sshd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [7:0]  payload_byte_o,
  input wire        last_of_payload_o,
  input wire [2:0]  status_o,
  input wire [31:0] packet_index_o
);
  import sshd_pkg::*;

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(last_of_payload_o) && $stable(status_o) && $stable(packet_index_o))
    else $error("result changed while stalled");

  // last marker only on data
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_payload_o |-> status_o == ST_DATA)
    else $error("last marker on a non-data result");

  // an error or disconnect is the final transaction until reset
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && status_o != ST_DATA |=> !out_valid_o)
    else $error("result after halt");

  // input back-pressure only from a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule : sshd_checker

bind ssh_packet_deframer_top sshd_checker u_sshd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .payload_byte_o    (payload_byte_o),
  .last_of_payload_o (last_of_payload_o),
  .status_o          (status_o),
  .packet_index_o    (packet_index_o)
);
`default_nettype wire
